>>> sv/vrs_pkg.sv
// Shared constants, CORDIC arctangent table and inter-stage structs for the
// vector rotate and scale pipeline. No dependencies.
`default_nettype none

package vrs_pkg;

  localparam int ANGLE_STEPS_DEF = 10;
  localparam int COORD_BITS_DEF  = 24;

  localparam int ANGLE_BITS = 13;
  localparam int SCALE_BITS = 16;
  localparam int SCALE_FRAC = 12;   // Q4.12
  localparam int TRIG_FRAC  = 16;   // Q1.16
  localparam int TRIG_W     = 18;   // signed, holds +-1.0 inclusive

  // Q2.30 phase and CORDIC datapath, one bit of headroom
  localparam int ZW = 33;

  localparam int CORDIC_ITERS    = 24;
  localparam int ITERS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;

  // register stages per unit
  localparam int PHASE_LAT  = 9;
  localparam int CORDIC_LAT = CORDIC_STAGES + 1;
  localparam int MULT_LAT   = 5;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam logic signed [ZW-1:0] INV_GAIN_Q30 = 33'sd652032874;

  localparam logic [ZW-2:0] ATAN_Q30 [CORDIC_ITERS] = '{
    32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  typedef struct packed {
    logic                 vld;
    logic                 neg;
    logic signed [ZW-1:0] z;
  } vrs_phase_t;

  typedef struct packed {
    logic                     vld;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } vrs_trig_t;

endpackage

`default_nettype wire

>>> sv/vector_rotate_and_scale.sv
// Vector rotate and scale: rotates (vec_x, vec_y) by turn_angle and scales by a Q4.12 factor.
// Register stages: phase 9, CORDIC 13, multiply 5, output register 1. Throughput: one
// word per clock while the spare output entry is empty, set by the fully pipelined
// CORDIC; a two-entry output buffer keeps in_ready a register.
// Reset (rst, synchronous) empties the pipeline and the output buffer; no other state.
`default_nettype none

module vector_rotate_and_scale #(
  parameter int ANGLE_STEPS_PER_DEGREE = vrs_pkg::ANGLE_STEPS_DEF,
  parameter int COORD_BITS             = vrs_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_BITS-1:0]          vec_x,
  input  logic signed [COORD_BITS-1:0]          vec_y,
  input  logic signed [vrs_pkg::ANGLE_BITS-1:0] turn_angle,
  input  logic [vrs_pkg::SCALE_BITS-1:0]        scale_factor,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_BITS-1:0]          new_x,
  output logic signed [COORD_BITS-1:0]          new_y,
  output logic                                  clipped
);
  import vrs_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int SD = PHASE_LAT + CORDIC_LAT;
  localparam int SW = 2 * CB + SCALE_BITS + 1;
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  logic en;
  vrs_phase_t ph;
  vrs_trig_t  trig;

  logic [SW-1:0] side_q [SD];
  logic [SW-1:0] side_end;

  logic                 res_valid, res_clip;
  logic signed [CB-1:0] res_x, res_y;

  logic                 skid_vld, skid_clip;
  logic signed [CB-1:0] skid_x, skid_y;

  // the whole pipeline moves unless the spare output entry is occupied
  assign en       = ~skid_vld;
  assign in_ready = en;

  vrs_phase #(
    .ANGLE_STEPS (ANGLE_STEPS_PER_DEGREE)
  ) u_phase (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .turn_angle (turn_angle),
    .ph         (ph)
  );

  vrs_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .ph   (ph),
    .trig (trig)
  );

  // operands that wait alongside the sine/cosine computation
  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= {vec_x, vec_y, scale_factor, turn_angle == '0};
      for (int i = 1; i < SD; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign side_end = side_q[SD-1];

  vrs_mult #(
    .COORD_BITS (COORD_BITS)
  ) u_mult (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .trig       (trig),
    .side_x     (side_end[SW-1 -: CB]),
    .side_y     (side_end[SW-CB-1 -: CB]),
    .side_scale (side_end[SCALE_BITS:1]),
    .side_zero  (side_end[0]),
    .res_valid  (res_valid),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_clip   (res_clip)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_vld) begin
        skid_vld <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (!out_valid) begin
      out_valid <= res_valid;
    end else if (res_valid && en) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready && skid_vld) begin
      new_x   <= skid_x;
      new_y   <= skid_y;
      clipped <= skid_clip;
    end else if ((!out_valid || out_ready) && !skid_vld) begin
      new_x   <= res_x;
      new_y   <= res_y;
      clipped <= res_clip;
    end
    if (out_valid && !out_ready && !skid_vld) begin
      skid_x    <= res_x;
      skid_y    <= res_y;
      skid_clip <= res_clip;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_valid)
    else $error("skid entry holds a word while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_vld) |-> $past(out_valid && !out_ready))
    else $error("skid entry filled without an output stall");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |->
      (new_x == CMAX || new_x == CMIN || new_y == CMAX || new_y == CMIN))
    else $error("clipped set but neither component sits at a rail");
`endif

endmodule

`default_nettype wire

>>> sv/vrs_phase.sv
// Angle reduction and conversion of the angle code to a Q2.30 phase.
// Nine register stages; uses vrs_pkg.
`default_nettype none

module vrs_phase #(
  parameter int ANGLE_STEPS = vrs_pkg::ANGLE_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [vrs_pkg::ANGLE_BITS-1:0] turn_angle,
  output vrs_pkg::vrs_phase_t                   ph
);
  import vrs_pkg::*;

  localparam longint FULL    = 360 * longint'(ANGLE_STEPS);
  localparam longint HALF    = 180 * longint'(ANGLE_STEPS);
  localparam longint QUARTER = 90 * longint'(ANGLE_STEPS);
  localparam int UB = ANGLE_BITS;
  localparam int AW = $clog2(FULL) + 2;
  localparam int AB = $clog2(QUARTER + 1);
  localparam int VB = $clog2(QUARTER * HALF);

  localparam logic [UB-1:0] RF      = UB'((longint'(1) << UB) / FULL);
  localparam logic [UB-1:0] FULL_LO = UB'(FULL);
  localparam logic signed [AW-1:0] FULL_A    = AW'(FULL);
  localparam logic signed [AW-1:0] HALF_A    = AW'(HALF);
  localparam logic signed [AW-1:0] QUARTER_A = AW'(QUARTER);
  localparam logic signed [AW-1:0] OFS_A     = AW'((longint'(1) << (UB - 1)) % FULL);
  localparam logic [ZW-2:0] PH_Q    = (ZW-1)'(PI_Q30 / HALF);
  localparam logic [VB-1:0] PH_R    = VB'(PI_Q30 % HALF);
  localparam logic [VB-1:0] PH_HALF = VB'(HALF);
  localparam logic [VB-1:0] RECIP   = VB'((longint'(1) << VB) / HALF);

  logic [PHASE_LAT-1:0] vld;

  // stage 1: offset-binary angle and quotient estimate by full turn
  logic [UB-1:0]   u;
  logic [2*UB-1:0] kprod;
  logic [UB-1:0]   s1_u, s1_k;
  // stage 2: remainder in [0, full turn)
  logic [2*UB-1:0] kf;
  logic [UB-1:0]   rraw, r_next;
  logic [UB-1:0]   s2_r;
  // stage 3: signed angle in (-half, half]
  logic signed [AW-1:0] m0, m1, a_next;
  logic signed [AW-1:0] s3_a;
  // stage 4: quarter fold, magnitude
  logic signed [AW-1:0] f, fmag;
  logic                 fneg;
  logic [AB-1:0]        s4_mag;
  logic                 s4_sgn, s4_neg;
  // stage 5..8: |a| * PI_Q30 / HALF as |a|*Q + floor(|a|*R / HALF)
  logic [ZW-2:0]   s5_p1;
  logic [VB-1:0]   s5_v;
  logic            s5_sgn, s5_neg;
  logic [2*VB-1:0] t;
  logic [AB-1:0]   s6_q;
  logic [VB-1:0]   s6_v;
  logic [ZW-2:0]   s6_p1;
  logic            s6_sgn, s6_neg;
  logic [VB-1:0]   s7_prod, s7_v;
  logic [AB-1:0]   s7_q;
  logic [ZW-2:0]   s7_p1;
  logic            s7_sgn, s7_neg;
  logic [VB-1:0]   rem;
  logic [ZW-2:0]   s8_zabs;
  logic            s8_sgn, s8_neg;
  // stage 9: signed phase
  logic signed [ZW-1:0] s9_z;
  logic                 s9_neg;

  assign u     = {~turn_angle[UB-1], turn_angle[UB-2:0]};
  assign kprod = {{UB{1'b0}}, u} * {{UB{1'b0}}, RF};

  // estimate never exceeds the true quotient, so the low bits of the product suffice
  assign kf     = {{UB{1'b0}}, s1_k} * {{UB{1'b0}}, FULL_LO};
  assign rraw   = s1_u - kf[UB-1:0];
  assign r_next = (rraw >= FULL) ? rraw - FULL_LO : rraw;

  assign m0     = $signed(AW'(s2_r)) - OFS_A;
  assign m1     = (m0 < 0) ? m0 + FULL_A : m0;
  assign a_next = (m1 > HALF_A) ? m1 - FULL_A : m1;

  always_comb begin
    if (s3_a > QUARTER_A) begin
      f    = s3_a - HALF_A;
      fneg = 1'b1;
    end else if (s3_a < -QUARTER_A) begin
      f    = s3_a + HALF_A;
      fneg = 1'b1;
    end else begin
      f    = s3_a;
      fneg = 1'b0;
    end
    fmag = f[AW-1] ? -f : f;
  end

  assign t   = {{VB{1'b0}}, s5_v} * {{VB{1'b0}}, RECIP};
  assign rem = s7_v - s7_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PHASE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_u    <= u;
      s1_k    <= kprod[2*UB-1:UB];
      s2_r    <= r_next;
      s3_a    <= a_next;
      s4_mag  <= fmag[AB-1:0];
      s4_sgn  <= f[AW-1];
      s4_neg  <= fneg;
      s5_p1   <= (ZW-1)'(s4_mag) * PH_Q;
      s5_v    <= VB'(s4_mag) * PH_R;
      s5_sgn  <= s4_sgn;
      s5_neg  <= s4_neg;
      s6_q    <= t[VB+AB-1:VB];
      s6_v    <= s5_v;
      s6_p1   <= s5_p1;
      s6_sgn  <= s5_sgn;
      s6_neg  <= s5_neg;
      s7_prod <= VB'(s6_q) * PH_HALF;
      s7_q    <= s6_q;
      s7_v    <= s6_v;
      s7_p1   <= s6_p1;
      s7_sgn  <= s6_sgn;
      s7_neg  <= s6_neg;
      // reciprocal estimate is at most one low
      s8_zabs <= s7_p1 + (ZW-1)'(s7_q) + (ZW-1)'(rem >= PH_HALF);
      s8_sgn  <= s7_sgn;
      s8_neg  <= s7_neg;
      s9_z    <= s8_sgn ? -$signed({1'b0, s8_zabs}) : $signed({1'b0, s8_zabs});
      s9_neg  <= s8_neg;
    end
  end

  assign ph = '{vld: vld[PHASE_LAT-1], neg: s9_neg, z: s9_z};

endmodule

`default_nettype wire

>>> sv/vrs_cordic.sv
// Pipelined CORDIC in rotation mode: Q2.30 phase to Q1.16 sine and cosine.
// Two iterations per register stage plus a rounding stage; uses vrs_pkg.
`default_nettype none

module vrs_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  vrs_pkg::vrs_phase_t ph,
  output vrs_pkg::vrs_trig_t  trig
);
  import vrs_pkg::*;

  localparam int NS = CORDIC_STAGES;
  localparam int RW = ZW + 1 - (30 - TRIG_FRAC);
  localparam logic signed [RW-1:0] ONE_P = RW'(longint'(1) << TRIG_FRAC);
  localparam logic signed [RW-1:0] ONE_N = -ONE_P;
  localparam logic signed [ZW:0]   RND   = (ZW+1)'(longint'(1) << (29 - TRIG_FRAC));

  logic signed [ZW-1:0] xi [NS];
  logic signed [ZW-1:0] yi [NS];
  logic signed [ZW-1:0] zi [NS];
  logic signed [ZW-1:0] xn [NS];
  logic signed [ZW-1:0] yn [NS];
  logic signed [ZW-1:0] zn [NS];
  logic signed [ZW-1:0] xr [NS];
  logic signed [ZW-1:0] yr [NS];
  logic signed [ZW-1:0] zr [NS];
  logic [NS-1:0] vr;
  logic [NS-1:0] nr;

  logic                     out_vld;
  logic signed [TRIG_W-1:0] cos_r, sin_r;

  function automatic logic signed [TRIG_W-1:0] to_q16(input logic signed [ZW-1:0] v,
                                                      input logic neg);
    logic signed [ZW:0]       vr1;
    logic signed [RW-1:0]     q;
    logic signed [TRIG_W-1:0] c;
    vr1 = {v[ZW-1], v} + RND;
    q   = vr1[ZW:30-TRIG_FRAC];
    if (q > ONE_P) begin
      q = ONE_P;
    end else if (q < ONE_N) begin
      q = ONE_N;
    end
    c = q[TRIG_W-1:0];
    return neg ? -c : c;
  endfunction

  assign xi[0] = INV_GAIN_Q30;
  assign yi[0] = '0;
  assign zi[0] = ph.z;

  for (genvar g = 1; g < NS; g++) begin : g_link
    assign xi[g] = xr[g-1];
    assign yi[g] = yr[g-1];
    assign zi[g] = zr[g-1];
  end

  always_comb begin
    logic signed [ZW-1:0] xt, yt, zt, xs, ys, at;
    for (int g = 0; g < NS; g++) begin
      xt = xi[g];
      yt = yi[g];
      zt = zi[g];
      for (int j = 0; j < ITERS_PER_STAGE; j++) begin
        xs = yt >>> (g * ITERS_PER_STAGE + j);
        ys = xt >>> (g * ITERS_PER_STAGE + j);
        at = $signed({1'b0, ATAN_Q30[g * ITERS_PER_STAGE + j]});
        if (!zt[ZW-1]) begin
          xt = xt - xs;
          yt = yt + ys;
          zt = zt - at;
        end else begin
          xt = xt + xs;
          yt = yt - ys;
          zt = zt + at;
        end
      end
      xn[g] = xt;
      yn[g] = yt;
      zn[g] = zt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr      <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vr      <= {vr[NS-2:0], ph.vld};
      out_vld <= vr[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nr <= {nr[NS-2:0], ph.neg};
      for (int g = 0; g < NS; g++) begin
        xr[g] <= xn[g];
        yr[g] <= yn[g];
        zr[g] <= zn[g];
      end
      cos_r <= to_q16(xr[NS-1], nr[NS-1]);
      sin_r <= to_q16(yr[NS-1], nr[NS-1]);
    end
  end

  assign trig = '{vld: out_vld, sin_v: sin_r, cos_v: cos_r};

endmodule

`default_nettype wire

>>> sv/vrs_mult.sv
// Rotation products, truncation, Q4.12 scaling and saturation.
// Five register stages; uses vrs_pkg.
`default_nettype none

module vrs_mult #(
  parameter int COORD_BITS = vrs_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  vrs_pkg::vrs_trig_t                  trig,
  input  logic signed [COORD_BITS-1:0]        side_x,
  input  logic signed [COORD_BITS-1:0]        side_y,
  input  logic [vrs_pkg::SCALE_BITS-1:0]      side_scale,
  input  logic                                side_zero,
  output logic                                res_valid,
  output logic signed [COORD_BITS-1:0]        res_x,
  output logic signed [COORD_BITS-1:0]        res_y,
  output logic                                res_clip
);
  import vrs_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int PW  = CB + TRIG_W;
  localparam int SW2 = PW + 1;
  localparam int RW  = CB + 2;
  localparam int MW  = RW + SCALE_BITS + 1;
  localparam int QW  = MW - SCALE_FRAC;
  localparam logic signed [SW2-1:0] TRND = SW2'((longint'(1) << TRIG_FRAC) - 1);
  localparam logic signed [MW-1:0]  SRND = MW'((longint'(1) << SCALE_FRAC) - 1);
  localparam logic signed [QW-1:0]  QMAX = QW'((longint'(1) << (CB - 1)) - 1);
  localparam logic signed [QW-1:0]  QMIN = -QW'(longint'(1) << (CB - 1));

  logic [MULT_LAT-2:0] vld;

  logic signed [PW-1:0] xe, ye, ce, se;
  logic signed [PW-1:0] m1_pxc, m1_pys, m1_pxs, m1_pyc;
  logic signed [CB-1:0] m1_x, m1_y, m2_x, m2_y;
  logic [SCALE_BITS-1:0] m1_sc, m2_sc, m3_sc;
  logic m1_zero, m2_zero;

  logic signed [SW2-1:0] m2_sx, m2_sy, sxb, syb;
  logic signed [RW-1:0]  rx_next, ry_next, m3_rx, m3_ry;

  logic signed [MW-1:0] rxe, rye, sce, m4_px, m4_py, pxb, pyb;
  logic signed [QW-1:0] qx, qy;

  assign xe = PW'(side_x);
  assign ye = PW'(side_y);
  assign ce = PW'(trig.cos_v);
  assign se = PW'(trig.sin_v);

  // truncation toward zero: bias negatives before the arithmetic shift
  assign sxb = m2_sx + (m2_sx[SW2-1] ? TRND : '0);
  assign syb = m2_sy + (m2_sy[SW2-1] ? TRND : '0);
  assign rx_next = m2_zero ? RW'(m2_x) : sxb[TRIG_FRAC+RW-1:TRIG_FRAC];
  assign ry_next = m2_zero ? RW'(m2_y) : syb[TRIG_FRAC+RW-1:TRIG_FRAC];

  assign rxe = MW'(m3_rx);
  assign rye = MW'(m3_ry);
  assign sce = $signed(MW'(m3_sc));

  assign pxb = m4_px + (m4_px[MW-1] ? SRND : '0);
  assign pyb = m4_py + (m4_py[MW-1] ? SRND : '0);
  assign qx  = pxb[MW-1:SCALE_FRAC];
  assign qy  = pyb[MW-1:SCALE_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[MULT_LAT-3:0], trig.vld};
      res_valid <= vld[MULT_LAT-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_pxc  <= xe * ce;
      m1_pys  <= ye * se;
      m1_pxs  <= xe * se;
      m1_pyc  <= ye * ce;
      m1_x    <= side_x;
      m1_y    <= side_y;
      m1_sc   <= side_scale;
      m1_zero <= side_zero;

      m2_sx   <= SW2'(m1_pxc) - SW2'(m1_pys);
      m2_sy   <= SW2'(m1_pxs) + SW2'(m1_pyc);
      m2_x    <= m1_x;
      m2_y    <= m1_y;
      m2_sc   <= m1_sc;
      m2_zero <= m1_zero;

      m3_rx   <= rx_next;
      m3_ry   <= ry_next;
      m3_sc   <= m2_sc;

      m4_px   <= rxe * sce;
      m4_py   <= rye * sce;

      if (qx > QMAX) begin
        res_x <= QMAX[CB-1:0];
      end else if (qx < QMIN) begin
        res_x <= QMIN[CB-1:0];
      end else begin
        res_x <= qx[CB-1:0];
      end
      if (qy > QMAX) begin
        res_y <= QMAX[CB-1:0];
      end else if (qy < QMIN) begin
        res_y <= QMIN[CB-1:0];
      end else begin
        res_y <= qy[CB-1:0];
      end
      res_clip <= (qx > QMAX) || (qx < QMIN) || (qy > QMAX) || (qy < QMIN);
    end
  end

endmodule

`default_nettype wire
